// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

  // one input word: a text character and the end marker
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       last;
  } out_word_t;

  // one decoded group handed from the front to the back
  typedef struct packed {
    logic [2:0][7:0] bytes;   // packed in emit order
    logic [1:0]      nbytes;  // 0 means a single status word
    logic            err;
    logic            last;
  } grp_t;

  localparam int unsigned GrpQueueDepth = 4;
  localparam int unsigned GrpPtrW       = $clog2(GrpQueueDepth);
  localparam int unsigned GrpCountW     = $clog2(GrpQueueDepth + 1);

  localparam logic [7:0] CharCr  = 8'd13;
  localparam logic [7:0] CharLf  = 8'd10;
  localparam logic [7:0] CharPad = 8'd61;

  // base64 alphabet to sextet, unknown characters give zero
  function automatic logic [5:0] sextet_of(input logic [6:0] ch);
    logic [5:0] s;
    s = 6'd0;
    if (ch >= 7'd65 && ch <= 7'd90) begin
      s = 6'(ch - 7'd65);
    end else if (ch >= 7'd97 && ch <= 7'd122) begin
      s = 6'(ch - 7'd71);
    end else if (ch >= 7'd48 && ch <= 7'd57) begin
      s = 6'(ch + 7'd4);
    end else if (ch == 7'd43) begin
      s = 6'd62;
    end else if (ch == 7'd47) begin
      s = 6'd63;
    end
    return s;
  endfunction

endpackage

// ===== sv/base64_stream_decoder.sv =====
// Streaming base64 decoder. One text character is taken per cycle; CR and LF
// between groups are skipped, and every four characters give up to three
// decoded bytes, one result word per cycle while popped. The front decodes
// groups into a four-deep group queue; the back unrolls each group into its
// words, so the input stalls (in_full) only when four decoded groups are
// waiting. A word with end_of_text closes the text: the final result carries
// last, and on a bad text (unfinished group or a character of 128 or above)
// it is a single word with decode_error set, after which all bytes of that
// text are to be discarded. A completed group is written to the group queue
// and then to the back's current group register before its first byte appears.
module base64_stream_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  b64d_pkg::in_word_t  in_word,
  output logic                out_empty,
  input  logic                out_pop,
  output b64d_pkg::out_word_t out_word
);

  b64d_pkg::grp_t push_word, head_word;
  logic           grp_push, grp_full, grp_pop, grp_empty;

  assign in_full = grp_full;

  // character front
  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .grp_full (grp_full),
    .grp_push (grp_push),
    .grp_word (push_word)
  );

  // decoded group queue
  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_push),
    .push_word (push_word),
    .full      (grp_full),
    .pop       (grp_pop),
    .head_word (head_word),
    .empty     (grp_empty)
  );

  // result back
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_word  (head_word),
    .grp_empty (grp_empty),
    .grp_pop   (grp_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== sv/b64d_front.sv =====
module b64d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  b64d_pkg::in_word_t in_word,
  input  logic               grp_full,
  output logic               grp_push,
  output b64d_pkg::grp_t     grp_word
);

  logic [1:0]      pos_r, pos_nxt;
  logic            tpad_r, tpad_nxt;
  logic            err_r, err_nxt;
  logic [2:0][5:0] held_r;

  logic       accept;
  logic       skip;
  logic       complete;
  logic       is_pad;
  logic [5:0] sext;
  logic [7:0] byte1, byte2, byte3;
  logic [1:0] nbytes;

  assign accept = in_push && !grp_full;

  // character classification
  always_comb begin
    skip     = (pos_r == 2'd0) &&
               (in_word.char_code == b64d_pkg::CharCr ||
                in_word.char_code == b64d_pkg::CharLf);
    is_pad   = (in_word.char_code == b64d_pkg::CharPad);
    sext     = in_word.char_code[7] ? 6'd0 : b64d_pkg::sextet_of(in_word.char_code[6:0]);
    complete = !skip && (pos_r == 2'd3);
  end

  // byte assembly of a completed group
  always_comb begin
    byte1  = {held_r[0], held_r[1][5:4]};
    byte2  = {held_r[1][3:0], held_r[2][5:2]};
    byte3  = {held_r[2][1:0], sext};
    nbytes = 2'd1 + {1'b0, !tpad_r} + {1'b0, !is_pad};
  end

  // next group state
  always_comb begin
    pos_nxt  = pos_r;
    tpad_nxt = tpad_r;
    err_nxt  = err_r | (!skip & in_word.char_code[7]);
    if (!skip) begin
      if (complete) begin
        pos_nxt  = 2'd0;
        tpad_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd2) begin
          tpad_nxt = is_pad;
        end
      end
    end
  end

  // group word toward the back
  always_comb begin
    grp_word.bytes[0] = byte1;
    grp_word.bytes[1] = tpad_r ? byte3 : byte2;
    grp_word.bytes[2] = byte3;
    grp_word.nbytes   = complete ? nbytes : 2'd0;
    grp_word.err      = 1'b0;
    grp_word.last     = in_word.end_of_text;
    if (in_word.end_of_text && (pos_nxt != 2'd0 || err_nxt)) begin
      grp_word.nbytes = 2'd0;
      grp_word.err    = 1'b1;
    end
    grp_push = accept && (complete || in_word.end_of_text);
  end

  // group state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      tpad_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (accept) begin
      if (in_word.end_of_text) begin
        pos_r  <= 2'd0;
        tpad_r <= 1'b0;
        err_r  <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        tpad_r <= tpad_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  // held sextets, written before read
  always_ff @(posedge clk) begin
    if (accept && !skip && !complete) begin
      held_r[pos_r] <= sext;
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
module b64d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::grp_t push_word,
  output logic           full,
  input  logic           pop,
  output b64d_pkg::grp_t head_word,
  output logic           empty
);

  b64d_pkg::grp_t                      mem_r [b64d_pkg::GrpQueueDepth];
  logic [b64d_pkg::GrpPtrW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [b64d_pkg::GrpCountW-1:0]      count_r;
  logic                                do_push, do_pop;

  assign full      = (count_r == b64d_pkg::GrpCountW'(b64d_pkg::GrpQueueDepth));
  assign empty     = (count_r == '0);
  assign head_word = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64d_back.sv =====
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::grp_t      grp_word,
  input  logic                grp_empty,
  output logic                grp_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output b64d_pkg::out_word_t out_word
);

  b64d_pkg::grp_t cur_r;
  logic           cur_valid_r;
  logic [1:0]     idx_r;
  logic [1:0]     last_idx;
  logic           final_word;
  logic           take;

  // index of the final word of the current group
  always_comb begin
    last_idx   = (cur_r.nbytes == 2'd0) ? 2'd0 : cur_r.nbytes - 2'd1;
    final_word = (idx_r == last_idx);
    take       = !cur_valid_r || (out_pop && final_word);
    grp_pop    = take && !grp_empty;
    out_empty  = !cur_valid_r;
  end

  // result word of the current position
  always_comb begin
    if (cur_r.nbytes == 2'd0) begin
      out_word.data_byte    = 8'd0;
      out_word.byte_valid   = 1'b0;
      out_word.decode_error = cur_r.err;
      out_word.last         = cur_r.last;
    end else begin
      out_word.data_byte    = cur_r.bytes[idx_r];
      out_word.byte_valid   = 1'b1;
      out_word.decode_error = 1'b0;
      out_word.last         = cur_r.last & final_word;
    end
  end

  // current group and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (take) begin
      cur_valid_r <= !grp_empty;
      idx_r       <= 2'd0;
    end else if (out_pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_pop) begin
      cur_r <= grp_word;
    end
  end

endmodule
